// ===== hdl/wspr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and tables for the WSPR message encoder.
package wspr_pkg;

  localparam int CALL_W      = 28;
  localparam int LOC_W       = 22;
  localparam int MSG_W       = CALL_W + LOC_W;
  localparam int CONV_W      = 32;
  localparam int NUM_CODED   = 162;
  localparam int NUM_BYTES   = 21;
  localparam int FRAME_W     = 8 * NUM_BYTES;
  localparam int ENC_STEPS   = 81;
  localparam int PACK_STEPS  = 6;
  localparam int CNT_W       = 7;
  localparam int IDX_W       = 5;

  localparam logic [CONV_W-1:0] POLY_A = 32'hF2D05351;
  localparam logic [CONV_W-1:0] POLY_B = 32'hE4613C47;

  // one received message
  typedef struct packed {
    logic [5:0][7:0]   call;
    logic [3:0][7:0]   grid;
    logic signed [6:0] power_dbm;
  } msg_t;

  // controller to datapath
  typedef struct packed {
    logic             capture;
    logic             pack;
    logic             load;
    logic             enc;
    logic             pop;
    logic             err_sel;
    logic [CNT_W-1:0] idx;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad_call;
  } dp_status_t;

  function automatic logic call_char_ok(input logic [7:0] c);
    logic ok;
    ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) || (c == 8'h20);
    return ok;
  endfunction

  // '0'..'9' -> 0..9, 'A'..'Z' -> 10..35, space -> 36
  function automatic logic [5:0] map_call_char(input logic [7:0] c);
    logic [5:0] v;
    v = 6'd36;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 6'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      v = 6'(c - 8'h41 + 8'd10);
    end
    return v;
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int b = 0; b < 8; b++) begin
      r[7-b] = v[b];
    end
    return r;
  endfunction

  typedef logic [7:0] ilv_tab_t [NUM_CODED];

  // coded bit number -> channel symbol position (bit-reversal interleave)
  function automatic ilv_tab_t build_ilv_tab();
    ilv_tab_t   tab;
    int         p;
    logic [7:0] j;
    tab = '{default: '0};
    p   = 0;
    for (int i = 0; i < 256; i++) begin
      j = rev8(8'(i));
      if (j < 8'(NUM_CODED)) begin
        tab[p] = j;
        p++;
      end
    end
    return tab;
  endfunction

  localparam ilv_tab_t ILV_TAB = build_ilv_tab();

endpackage

// ===== hdl/wspr_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for message input and frame output.
interface wspr_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        call_char0;
  logic [7:0]        call_char1;
  logic [7:0]        call_char2;
  logic [7:0]        call_char3;
  logic [7:0]        call_char4;
  logic [7:0]        call_char5;
  logic [7:0]        grid_char0;
  logic [7:0]        grid_char1;
  logic [7:0]        grid_char2;
  logic [7:0]        grid_char3;
  logic signed [6:0] power_dbm;

  modport source (
    output valid, call_char0, call_char1, call_char2, call_char3, call_char4,
           call_char5, grid_char0, grid_char1, grid_char2, grid_char3, power_dbm,
    input  ready
  );
  modport sink (
    input  valid, call_char0, call_char1, call_char2, call_char3, call_char4,
           call_char5, grid_char0, grid_char1, grid_char2, grid_char3, power_dbm,
    output ready
  );
endinterface

interface wspr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] channel_byte;
  logic [4:0] byte_index;
  logic       last_byte;
  logic       bad_callsign;

  modport source (
    output valid, channel_byte, byte_index, last_byte, bad_callsign,
    input  ready
  );
  modport sink (
    input  valid, channel_byte, byte_index, last_byte, bad_callsign,
    output ready
  );
endinterface

// ===== hdl/wspr_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing controller: check, pack, load, encode, frame output and error phases.
module wspr_ctrl
  import wspr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_PACK,
    S_LOAD,
    S_ENC,
    S_OUT,
    S_ERR
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pending_r, pending_nxt;
  logic             accept;

  always_comb begin
    in_ready = (state_r == S_IDLE) ||
               (((state_r == S_OUT) || (state_r == S_ERR)) && !pending_r);
    accept   = in_valid && in_ready;

    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    pending_nxt = pending_r;
    out_valid   = 1'b0;
    cmd         = '0;
    cmd.idx     = cnt_r;
    cmd.capture = accept;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cnt_nxt   = '0;
        state_nxt = status.bad_call ? S_ERR : S_PACK;
      end
      S_PACK: begin
        cmd.pack = 1'b1;
        if (cnt_r == CNT_W'(PACK_STEPS - 1)) begin
          state_nxt = S_LOAD;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_ENC;
      end
      S_ENC: begin
        cmd.enc = 1'b1;
        if (cnt_r == CNT_W'(ENC_STEPS - 1)) begin
          state_nxt = S_OUT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (accept) begin
          pending_nxt = 1'b1;
        end
        if (out_ready) begin
          cmd.pop = 1'b1;
          if (cnt_r == CNT_W'(NUM_BYTES - 1)) begin
            state_nxt   = (pending_r || accept) ? S_CHECK : S_IDLE;
            pending_nxt = 1'b0;
            cnt_nxt     = '0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_ERR: begin
        out_valid   = 1'b1;
        cmd.err_sel = 1'b1;
        if (accept) begin
          pending_nxt = 1'b1;
        end
        if (out_ready) begin
          state_nxt   = (pending_r || accept) ? S_CHECK : S_IDLE;
          pending_nxt = 1'b0;
          cnt_nxt     = '0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      pending_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      pending_r <= pending_nxt;
    end
  end

endmodule

// ===== hdl/wspr_dp.sv =====
`timescale 1ns / 1ps
// Datapath: message registers, packing, convolutional encoder and frame buffer.
module wspr_dp
  import wspr_pkg::*;
(
  input  logic             clk,
  input  msg_t             msg,
  input  dp_cmd_t          cmd,
  output dp_status_t       status,
  output logic [7:0]       channel_byte,
  output logic [IDX_W-1:0] byte_index,
  output logic             last_byte,
  output logic             bad_callsign
);

  msg_t               msg_r;
  logic [CALL_W-1:0]  call_r, call_nxt;
  logic [LOC_W-1:0]   loc_r, loc_nxt;
  logic [LOC_W-1:0]   aux_r, aux_nxt;
  logic [MSG_W-1:0]   bits_r, bits_nxt;
  logic [CONV_W-1:0]  conv_r, conv_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic [7:0]         sel_char;
  logic [5:0]         m;
  logic [LOC_W-1:0]   pwr_ext;
  logic [7:0]         p0, p1;

  always_comb begin
    status.bad_call = 1'b0;
    for (int k = 0; k < 6; k++) begin
      if (!call_char_ok(msg_r.call[k])) begin
        status.bad_call = 1'b1;
      end
    end
  end

  always_comb begin
    case (cmd.idx[2:0])
      3'd0:    sel_char = msg_r.call[0];
      3'd1:    sel_char = msg_r.call[1];
      3'd2:    sel_char = msg_r.call[2];
      3'd3:    sel_char = msg_r.call[3];
      3'd4:    sel_char = msg_r.call[4];
      3'd5:    sel_char = msg_r.call[5];
      default: sel_char = msg_r.call[0];
    endcase
    m       = map_call_char(sel_char);
    pwr_ext = {{(LOC_W - 7){msg_r.power_dbm[6]}}, msg_r.power_dbm};
    p0      = {cmd.idx, 1'b0};
    p1      = {cmd.idx, 1'b1};
  end

  always_comb begin
    call_nxt  = call_r;
    loc_nxt   = loc_r;
    aux_nxt   = aux_r;
    bits_nxt  = bits_r;
    conv_nxt  = conv_r;
    frame_nxt = frame_r;

    if (cmd.pack) begin
      case (cmd.idx[2:0])
        3'd0: begin
          call_nxt = CALL_W'(m);
          loc_nxt  = LOC_W'(179)
                   - LOC_W'(LOC_W'(10) * (LOC_W'(msg_r.grid[0]) - LOC_W'(8'h41)))
                   - (LOC_W'(msg_r.grid[2]) - LOC_W'(8'h30));
          aux_nxt  = LOC_W'(LOC_W'(10) * (LOC_W'(msg_r.grid[1]) - LOC_W'(8'h41)))
                   + (LOC_W'(msg_r.grid[3]) - LOC_W'(8'h30));
        end
        3'd1: begin
          call_nxt = CALL_W'(call_r * CALL_W'(36)) + CALL_W'(m);
          loc_nxt  = LOC_W'(loc_r * LOC_W'(180)) + aux_r;
        end
        3'd2: begin
          call_nxt = CALL_W'(call_r * CALL_W'(10)) + CALL_W'(m);
          loc_nxt  = {loc_r[LOC_W-8:0], 7'd0} + pwr_ext + LOC_W'(64);
        end
        default: begin
          // letter or space positions: offset by ten
          call_nxt = CALL_W'(call_r * CALL_W'(27)) + CALL_W'(m) - CALL_W'(10);
        end
      endcase
    end

    if (cmd.load) begin
      bits_nxt  = {call_r, loc_r};
      conv_nxt  = '0;
      frame_nxt = '0;
    end

    if (cmd.enc) begin
      conv_nxt            = {conv_r[CONV_W-2:0], bits_r[MSG_W-1]};
      bits_nxt            = {bits_r[MSG_W-2:0], 1'b0};
      frame_nxt[ILV_TAB[p0]] = ^(conv_nxt & POLY_A);
      frame_nxt[ILV_TAB[p1]] = ^(conv_nxt & POLY_B);
    end

    if (cmd.pop) begin
      frame_nxt = {8'd0, frame_r[FRAME_W-1:8]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      msg_r <= msg;
    end
    call_r  <= call_nxt;
    loc_r   <= loc_nxt;
    aux_r   <= aux_nxt;
    bits_r  <= bits_nxt;
    conv_r  <= conv_nxt;
    frame_r <= frame_nxt;
  end

  assign channel_byte = cmd.err_sel ? 8'd0 : frame_r[7:0];
  assign byte_index   = cmd.err_sel ? '0 : cmd.idx[IDX_W-1:0];
  assign last_byte    = cmd.err_sel || (cmd.idx == CNT_W'(NUM_BYTES - 1));
  assign bad_callsign = cmd.err_sel;

endmodule

// ===== hdl/wspr_message_encoder_unit.sv =====
`timescale 1ns / 1ps
// WSPR message encoder top level: one message in, 21 interleaved channel bytes out.
//
// After acceptance the callsign is checked, callsign and locator are packed
// step by step, the message register is loaded, and the convolutional encoder
// shifts one message bit per cycle and writes both parity bits straight to
// their interleaved frame positions; then the first frame byte is offered. The
// 21 frame bytes follow one per cycle while the sink is ready. A message with
// an invalid callsign character gives a single error word after the check
// state instead. While a frame is being drained the next message is taken and
// held, and its processing starts once the last word has gone.
module wspr_message_encoder_unit
  import wspr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  wspr_in_if.sink    in_msg,
  wspr_out_if.source out_frame
);

  msg_t       msg;
  dp_cmd_t    cmd;
  dp_status_t status;

  assign msg.call[0]   = in_msg.call_char0;
  assign msg.call[1]   = in_msg.call_char1;
  assign msg.call[2]   = in_msg.call_char2;
  assign msg.call[3]   = in_msg.call_char3;
  assign msg.call[4]   = in_msg.call_char4;
  assign msg.call[5]   = in_msg.call_char5;
  assign msg.grid[0]   = in_msg.grid_char0;
  assign msg.grid[1]   = in_msg.grid_char1;
  assign msg.grid[2]   = in_msg.grid_char2;
  assign msg.grid[3]   = in_msg.grid_char3;
  assign msg.power_dbm = in_msg.power_dbm;

  wspr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_msg.valid),
    .in_ready  (in_msg.ready),
    .out_valid (out_frame.valid),
    .out_ready (out_frame.ready),
    .status    (status),
    .cmd       (cmd)
  );

  wspr_dp u_dp (
    .clk          (clk),
    .msg          (msg),
    .cmd          (cmd),
    .status       (status),
    .channel_byte (out_frame.channel_byte),
    .byte_index   (out_frame.byte_index),
    .last_byte    (out_frame.last_byte),
    .bad_callsign (out_frame.bad_callsign)
  );

  // a taken message blocks further input until processing starts
  assert property (@(posedge clk) disable iff (!rst_n)
    in_msg.valid && in_msg.ready |=> !in_msg.ready)
    else $error("input accepted twice in a row");

  // nothing is offered in the cycle after the final word of a message
  assert property (@(posedge clk) disable iff (!rst_n)
    out_frame.valid && out_frame.ready && out_frame.last_byte |=> !out_frame.valid)
    else $error("output word after last_byte");

  // frame words go out with consecutive indices
  assert property (@(posedge clk) disable iff (!rst_n)
    out_frame.valid && out_frame.ready && !out_frame.last_byte |=>
      out_frame.valid && (out_frame.byte_index == $past(out_frame.byte_index) + 5'd1))
    else $error("frame byte index not consecutive");

endmodule
